### rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Widths, payload types and the inter-cell record of the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int FRACTION_BITS = 16;

   // Hue divisor is six times the chroma.
   localparam int HUE_DIV_BITS = CHANNEL_BITS + 3;
   localparam int SAT_REM_BITS = CHANNEL_BITS + 1;
   localparam int HUE_REM_BITS = CHANNEL_BITS + 4;
   localparam int QUOT_BITS    = FRACTION_BITS + 1;
   localparam int CELL_COUNT   = FRACTION_BITS + 1;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] hue;
      logic [FRACTION_BITS:0]   saturation;
      logic [CHANNEL_BITS-1:0]  value_out;
   } rsp_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] value;
      logic [HUE_DIV_BITS-1:0] hue_div;
      logic [SAT_REM_BITS-1:0] sat_rem;
      logic [HUE_REM_BITS-1:0] hue_rem;
      logic [QUOT_BITS-1:0]    sat_quot;
      logic [QUOT_BITS-1:0]    hue_quot;
   } cell_type;

endpackage

`default_nettype wire

### rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Finds value, chroma and the hue sector numerator, and seeds the divider row.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire rhc_pkg::req_type  in_data,
   output logic                   out_valid,
   output rhc_pkg::cell_type      out_data
);

   localparam int CB = rhc_pkg::CHANNEL_BITS;
   localparam int HR = rhc_pkg::HUE_REM_BITS;

   logic                valid_ff;
   logic                valid_in;
   rhc_pkg::cell_type   data_ff;
   rhc_pkg::cell_type   data_in;

   logic [CB-1:0] max_value;
   logic [CB-1:0] min_value;
   logic [CB-1:0] chroma;
   logic [HR-1:0] r_ext;
   logic [HR-1:0] g_ext;
   logic [HR-1:0] b_ext;
   logic [HR-1:0] c_ext;
   logic [HR-1:0] numerator;

   always_comb begin
      max_value = in_data.red;
      if (in_data.green > max_value) max_value = in_data.green;
      if (in_data.blue > max_value) max_value = in_data.blue;
      min_value = in_data.red;
      if (in_data.green < min_value) min_value = in_data.green;
      if (in_data.blue < min_value) min_value = in_data.blue;
      chroma = max_value - min_value;

      r_ext = HR'(in_data.red);
      g_ext = HR'(in_data.green);
      b_ext = HR'(in_data.blue);
      c_ext = HR'(chroma);

      // Sector offsets are taken modulo the register width; the true sum is nonnegative.
      if (chroma == '0) begin
         numerator = '0;
      end else if (max_value == in_data.red) begin
         if (in_data.green >= in_data.blue) begin
            numerator = g_ext - b_ext;
         end else begin
            numerator = HR'(6) * c_ext - (b_ext - g_ext);
         end
      end else if (max_value == in_data.green) begin
         numerator = HR'(2) * c_ext + b_ext - r_ext;
      end else begin
         numerator = HR'(4) * c_ext + r_ext - g_ext;
      end

      data_in          = data_ff;
      data_in.value    = max_value;
      data_in.hue_div  = rhc_pkg::HUE_DIV_BITS'(HR'(6) * c_ext);
      data_in.sat_rem  = rhc_pkg::SAT_REM_BITS'(chroma);
      data_in.hue_rem  = numerator;
      data_in.sat_quot = '0;
      data_in.hue_quot = '0;
      valid_in         = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### rtl/rhc_cell.sv
// ----------------------------------------------------------------------------
// rhc_cell
// One restoring-division step for both saturation and hue, one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire rhc_pkg::cell_type  in_data,
   output logic                    out_valid,
   output rhc_pkg::cell_type       out_data
);

   localparam int SR = rhc_pkg::SAT_REM_BITS;
   localparam int HR = rhc_pkg::HUE_REM_BITS;
   localparam int QB = rhc_pkg::QUOT_BITS;

   logic                valid_ff;
   logic                valid_in;
   rhc_pkg::cell_type   data_ff;
   rhc_pkg::cell_type   data_in;

   logic          sat_take;
   logic          hue_take;
   logic [SR-1:0] sat_left;
   logic [HR-1:0] hue_left;

   always_comb begin
      sat_take = in_data.sat_rem >= SR'(in_data.value);
      sat_left = sat_take ? in_data.sat_rem - SR'(in_data.value) : in_data.sat_rem;
      hue_take = in_data.hue_rem >= HR'(in_data.hue_div);
      hue_left = hue_take ? in_data.hue_rem - HR'(in_data.hue_div) : in_data.hue_rem;

      data_in          = in_data;
      data_in.sat_rem  = {sat_left[SR-2:0], 1'b0};
      data_in.hue_rem  = {hue_left[HR-2:0], 1'b0};
      data_in.sat_quot = {in_data.sat_quot[QB-2:0], sat_take};
      data_in.hue_quot = {in_data.hue_quot[QB-2:0], hue_take};
      valid_in         = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV pixel conversion with exact truncated fractions.
// ----------------------------------------------------------------------------
// A pixel is offered on req_valid/req_data and a transfer takes place when
// req_ready is also high. The result appears on rsp_valid/rsp_data and is
// held until the receiver takes it with rsp_ready.
// The registered front stage finds value, chroma and the hue numerator.
// A row of FRACTION_BITS + 1 division cells follows, each producing one
// saturation bit and one hue bit per cycle while the row is not held.
// One pixel is accepted every cycle while the receiver keeps up.
// When the receiver stalls with a result waiting, the whole row holds and
// req_ready goes low until that result is taken.
// Reset clears all valid flags; the row comes up empty and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rhc_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rhc_pkg::rsp_type       rsp_data
);

   localparam int N  = rhc_pkg::CELL_COUNT;
   localparam int FB = rhc_pkg::FRACTION_BITS;

   logic               enable;
   logic               stage_valid [0:N];
   rhc_pkg::cell_type  stage_data  [0:N];

   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   for (genvar k = 0; k < N; k++) begin : g_cell
      rhc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // A black pixel has zero saturation and a grey pixel zero hue.
   always_comb begin
      rsp_valid          = stage_valid[N];
      rsp_data.value_out = stage_data[N].value;
      rsp_data.saturation = (stage_data[N].value == '0) ? '0 : stage_data[N].sat_quot;
      rsp_data.hue = (stage_data[N].hue_div == '0) ? '0 : stage_data[N].hue_quot[FB-1:0];
   end

endmodule

`default_nettype wire
